// ===== src/clbp_pkg.sv =====
// ----------------------------------------------------------------------------
// clbp_pkg: shared types and constants for the circular LBP block
// Holds the frame geometry limits, the configuration register indexes, the
// 3x3 window type and the bilinear diagonal sample compare.
// ----------------------------------------------------------------------------
`default_nettype none

package clbp_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned MinDim    = 3;

  localparam int unsigned PixW = 8;
  localparam int unsigned DimW = 11;                  // width of a geometry register
  localparam int unsigned ColW = $clog2(MaxWidth);    // column counter and line address
  localparam int unsigned RowW = $clog2(MaxHeight);
  localparam int unsigned LineW = 2 * PixW;           // row-1 in low byte, row-2 in high

  localparam int unsigned ResetWidth  = 640;
  localparam int unsigned ResetHeight = 490;

  // Q0.16 bilinear weights; centre weight folded into the compare side
  localparam int unsigned WSide   = 13573;
  localparam int unsigned WCorner = 32768;
  localparam int unsigned WCmp    = 65536 - 5622;
  localparam int unsigned SumW    = 25;

  typedef enum logic [0:0] {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_index_e;

  // 3x3 neighbourhood: a = column-2, b = column-1 (centre), c = current column;
  // t = row-2, m = row-1, b = current row
  typedef struct packed {
    logic [PixW-1:0] at;
    logic [PixW-1:0] am;
    logic [PixW-1:0] ab;
    logic [PixW-1:0] bt;
    logic [PixW-1:0] bm;
    logic [PixW-1:0] bb;
    logic [PixW-1:0] ct;
    logic [PixW-1:0] cm;
    logic [PixW-1:0] cb;
  } win_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] hi);
    logic [DimW-1:0] r;
    if (v < DimW'(MinDim)) begin
      r = DimW'(MinDim);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Interpolated diagonal sample strictly above the centre
  function automatic logic diag_above(input logic [PixW-1:0] c,
                                      input logic [PixW-1:0] h,
                                      input logic [PixW-1:0] v,
                                      input logic [PixW-1:0] k);
    logic [SumW-1:0] lhs;
    logic [SumW-1:0] rhs;
    lhs = SumW'(WSide) * (SumW'(h) + SumW'(v)) + SumW'(WCorner) * SumW'(k);
    rhs = SumW'(WCmp) * SumW'(c);
    return lhs > rhs;
  endfunction

endpackage

`default_nettype wire

// ===== src/clbp_ram.sv =====
// ----------------------------------------------------------------------------
// clbp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data; the read
// data holds while no read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module clbp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/clbp_code.sv =====
// ----------------------------------------------------------------------------
// clbp_code: radius-1, 8-point circular LBP code of one 3x3 window
// Axis points compare exact pixels; diagonal points compare the bilinear
// sample against the centre.
// ----------------------------------------------------------------------------
`default_nettype none

module clbp_code (
  input  wire clbp_pkg::win_t              win_i,
  output logic [clbp_pkg::PixW-1:0]        code_o
);

  always_comb begin
    code_o[0] = win_i.cm > win_i.bm;                                          // right
    code_o[1] = clbp_pkg::diag_above(win_i.bm, win_i.cm, win_i.bb, win_i.cb); // down-right
    code_o[2] = win_i.bb > win_i.bm;                                          // down
    code_o[3] = clbp_pkg::diag_above(win_i.bm, win_i.am, win_i.bb, win_i.ab); // down-left
    code_o[4] = win_i.am > win_i.bm;                                          // left
    code_o[5] = clbp_pkg::diag_above(win_i.bm, win_i.am, win_i.bt, win_i.at); // up-left
    code_o[6] = win_i.bt > win_i.bm;                                          // up
    code_o[7] = clbp_pkg::diag_above(win_i.bm, win_i.cm, win_i.bt, win_i.ct); // up-right
  end

endmodule

`default_nettype wire

// ===== src/circular_lbp_bilinear.sv =====
// ----------------------------------------------------------------------------
// circular_lbp_bilinear: streaming circular LBP (radius 1, 8 points)
// Takes grey pixels in raster order and gives one 8-bit pattern code for
// every interior centre pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one pixel per item, tuser marks the first pixel of a
//   frame and restarts the position counters. Master channel: one code per
//   interior centre (the pixel one row up and one column left of the pixel
//   just taken), tlast on the last code of a row, tuser on the last code of
//   the frame. Border positions give no item.
//   Config channel: index 0 = image width, index 1 = image height, clamped
//   to 3..1024 on write; write only while the block is idle.
// Timing:
//   One pixel is taken every cycle unless a stall holds it (see below).
//   Its code passes through the stage 1 register and the code register.
//   The line store is a single 1024 x 16 RAM with one read and one write
//   per pixel, which sets the rate at one pixel per clock when not stalled.
// Reset and stalls:
//   Reset clears counters, window and output valid; the line store is not
//   cleared and its rows are valid once written by the first two rows.
//   When the receiver stalls, the code register holds; the input stage
//   keeps taking pixels that give no code, and stalls once a pixel that
//   gives a code cannot move into the code register.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_lbp_bilinear (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,

  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [7:0]                  s_axis_tdata_i,   // [7:0] pixel
  input  wire logic                        s_axis_tuser_i,   // [0] frame_start

  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  output logic [7:0]                       m_axis_tdata_o,   // [7:0] pattern_code
  output logic                             m_axis_tlast_o,   // row_end
  output logic                             m_axis_tuser_o,   // [0] frame_end

  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic                        cfg_index_i,
  input  wire logic [clbp_pkg::DimW-1:0]   cfg_data_i
);

  localparam int unsigned PixW  = clbp_pkg::PixW;
  localparam int unsigned DimW  = clbp_pkg::DimW;
  localparam int unsigned ColW  = clbp_pkg::ColW;
  localparam int unsigned RowW  = clbp_pkg::RowW;
  localparam int unsigned LineW = clbp_pkg::LineW;

  // --------------------------------------------------------------------------
  // Geometry registers, stored already clamped
  // --------------------------------------------------------------------------
  logic [DimW-1:0] width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(clbp_pkg::ResetWidth);
      height_q <= DimW'(clbp_pkg::ResetHeight);
    end else if (cfg_valid_i) begin
      case (clbp_pkg::cfg_index_e'(cfg_index_i))
        clbp_pkg::CfgImageWidth: begin
          width_q <= clbp_pkg::clamp_dim(cfg_data_i, DimW'(clbp_pkg::MaxWidth));
        end
        clbp_pkg::CfgImageHeight: begin
          height_q <= clbp_pkg::clamp_dim(cfg_data_i, DimW'(clbp_pkg::MaxHeight));
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: accepted pixel and its position; line store read in flight
  // --------------------------------------------------------------------------
  logic            s1_valid_q;
  logic [PixW-1:0] s1_pix_q;
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;
  logic            s1_hit, s1_adv;
  logic            in_acc;

  logic [ColW-1:0] col_q, col_d, in_col;
  logic [RowW-1:0] row_q, row_d, in_row;

  logic              out_valid_q;
  logic [PixW-1:0]   out_code_q;
  logic              out_last_q, out_fend_q;

  assign s1_hit = s1_valid_q
                && (s1_col_q >= ColW'(2)) && (s1_row_q >= RowW'(2))
                && (DimW'(s1_col_q) < width_q) && (DimW'(s1_row_q) < height_q);

  // A pixel with no code always moves on; one with a code needs a free slot
  assign s1_adv = s1_valid_q && (!s1_hit || !out_valid_q || m_axis_tready_i);

  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Position of the incoming pixel; frame_start restarts at the origin
  assign in_col = s_axis_tuser_i ? '0 : col_q;
  assign in_row = s_axis_tuser_i ? '0 : row_q;

  always_comb begin
    col_d = in_col;
    row_d = in_row;
    if (DimW'(in_col) + DimW'(1) >= width_q) begin
      col_d = '0;
      row_d = (DimW'(in_row) + DimW'(1) >= height_q) ? '0 : in_row + RowW'(1);
    end else begin
      col_d = in_col + ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q <= s_axis_tdata_i;
      s1_col_q <= in_col;
      s1_row_q <= in_row;
    end
  end

  // --------------------------------------------------------------------------
  // Line store: read at accept, write back when stage 1 advances
  // --------------------------------------------------------------------------
  logic [LineW-1:0] line_rdata, line_wdata, line_word;
  logic             byp_q;
  logic [LineW-1:0] byp_data_q;

  clbp_ram #(
    .Width (LineW),
    .Depth (clbp_pkg::MaxWidth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (line_wdata),
    .re_i    (in_acc),
    .raddr_i (in_col),
    .rdata_o (line_rdata)
  );

  // Forward a write that lands on the address read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (in_acc) begin
      byp_q <= s1_adv && (s1_col_q == in_col);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byp_data_q <= line_wdata;
    end
  end

  assign line_word  = byp_q ? byp_data_q : line_rdata;
  assign line_wdata = {line_word[PixW-1:0], s1_pix_q};

  // --------------------------------------------------------------------------
  // Window: columns at column-2 and column-1; shift on every advance
  // --------------------------------------------------------------------------
  clbp_pkg::win_t win;
  logic [PixW-1:0] at_q, am_q, ab_q, bt_q, bm_q, bb_q;
  logic [PixW-1:0] code;

  assign win = '{at: at_q, am: am_q, ab: ab_q,
                 bt: bt_q, bm: bm_q, bb: bb_q,
                 ct: line_word[LineW-1:PixW], cm: line_word[PixW-1:0], cb: s1_pix_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_q <= '0;
      am_q <= '0;
      ab_q <= '0;
      bt_q <= '0;
      bm_q <= '0;
      bb_q <= '0;
    end else if (s1_adv) begin
      at_q <= win.bt;
      am_q <= win.bm;
      ab_q <= win.bb;
      bt_q <= win.ct;
      bm_q <= win.cm;
      bb_q <= win.cb;
    end
  end

  clbp_code u_code (
    .win_i  (win),
    .code_o (code)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_hit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_hit) begin
      out_code_q <= code;
      out_last_q <= DimW'(s1_col_q) == width_q - DimW'(1);
      out_fend_q <= (DimW'(s1_col_q) == width_q - DimW'(1))
                 && (DimW'(s1_row_q) == height_q - DimW'(1));
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_code_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_fend_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fend_has_rend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("frame end without row end");

  a_geom_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    width_q >= DimW'(clbp_pkg::MinDim) && width_q <= DimW'(clbp_pkg::MaxWidth)
    && height_q >= DimW'(clbp_pkg::MinDim) && height_q <= DimW'(clbp_pkg::MaxHeight))
    else $error("geometry register out of clamp range");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_hit |-> !out_valid_q || m_axis_tready_i)
    else $error("code register overwritten while held");

  a_stall_holds_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_col_q) && $stable(s1_row_q))
    else $error("stalled pixel lost its position");

endmodule

`default_nettype wire
